FILE: sv/utf16_to_utf8_encoder_core_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the utf-16 to utf-8 encoder
// ---------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_CORE_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_CORE_ASSERT_SVH

// checked property, held off while reset is asserted
`define U2U8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property that must also hold during reset
`define U2U8_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/u2u8_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8_pkg
// types, constants and the code point encoder shared by the encoder modules
// ---------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned HELD_W      = 10;
  localparam int unsigned MAX_BYTES   = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // surrogate prefixes on the top six bits of a unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT   = 8'h80;

  // offset of a supplementary plane as added to the high surrogate bits
  localparam logic [HELD_W:0] PLANE_OFS = 11'h040;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] b;
    logic [CNT_W-1:0]       len;
  } enc_t;

  // one job: the bytes a single unit produces
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] b;
    logic [CNT_W-1:0]                 cnt;
    logic                             last;
  } job_t;

  function automatic enc_t encode_cp(input logic [CP_W-1:0] c);
    enc_t e;
    e.b = '0;
    if (c[CP_W-1:7] == '0) begin
      e.b[0] = {1'b0, c[6:0]};
      e.len  = 3'd1;
    end else if (c[CP_W-1:11] == '0) begin
      e.b[0] = LEAD_2 | {3'b000, c[10:6]};
      e.b[1] = CONT | {2'b00, c[5:0]};
      e.len  = 3'd2;
    end else if (c[CP_W-1:16] == '0) begin
      e.b[0] = LEAD_3 | {4'b0000, c[15:12]};
      e.b[1] = CONT | {2'b00, c[11:6]};
      e.b[2] = CONT | {2'b00, c[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = LEAD_4 | {5'b00000, c[20:18]};
      e.b[1] = CONT | {2'b00, c[17:12]};
      e.b[2] = CONT | {2'b00, c[11:6]};
      e.b[3] = CONT | {2'b00, c[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

FILE: sv/u2u8_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8 channel interfaces
// valid/ready channels for utf-16 units in and utf-8 bytes out
// ---------------------------------------------------------------------------
interface u2u8_unit_if
  import u2u8_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_byte_if
  import u2u8_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

FILE: sv/u2u8_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8_front
// classifies units, pairs surrogates and builds at most one byte job per unit
// ---------------------------------------------------------------------------
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  u2u8_unit_if.sink   in_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [HELD_W-1:0] held_q, held_d;
  logic              pend_q, pend_d;
  logic              accept, is_high, is_low, pair, flush, hold;
  logic [CP_W-1:0]   new_cp, flush_cp;
  enc_t              enc_new, enc_flush;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign is_high = in_i.code_unit[15:10] == HIGH_SURR_TAG;
  assign is_low  = in_i.code_unit[15:10] == LOW_SURR_TAG;
  assign pair    = pend_q && is_low;
  assign flush   = pend_q && !is_low;
  assign hold    = is_high && !in_i.last_unit;

  assign new_cp   = pair ? {{1'b0, held_q} + PLANE_OFS, in_i.code_unit[9:0]}
                         : {5'b00000, in_i.code_unit};
  assign flush_cp = {5'b00000, HIGH_SURR_TAG, held_q};

  assign enc_new   = encode_cp(new_cp);
  assign enc_flush = encode_cp(flush_cp);

  always_comb begin
    job_o      = '0;
    job_o.last = in_i.last_unit;
    if (flush) begin
      job_o.b[0] = enc_flush.b[0];
      job_o.b[1] = enc_flush.b[1];
      job_o.b[2] = enc_flush.b[2];
      if (hold) begin
        job_o.cnt = 3'd3;
      end else begin
        job_o.b[3] = enc_new.b[0];
        job_o.b[4] = enc_new.b[1];
        job_o.b[5] = enc_new.b[2];
        job_o.cnt  = 3'd3 + enc_new.len;
      end
    end else begin
      job_o.b[0] = enc_new.b[0];
      job_o.b[1] = enc_new.b[1];
      job_o.b[2] = enc_new.b[2];
      job_o.b[3] = enc_new.b[3];
      job_o.cnt  = hold ? 3'd0 : enc_new.len;
    end
  end

  // a held high surrogate yields no job until the next unit
  assign push_o = accept && (job_o.cnt != '0);

  always_comb begin
    pend_d = pend_q;
    held_d = held_q;
    if (accept) begin
      pend_d = hold;
      held_d = hold ? in_i.code_unit[9:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
    end else begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule

FILE: sv/u2u8_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8_queue
// short job queue between the front and back halves
// ---------------------------------------------------------------------------
`include "utf16_to_utf8_encoder_core_assert.svh"

module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == CntW'(Depth);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `U2U8_ASSERT(a_no_overflow, push_i |-> !full_o || pop_i, "job pushed into full queue")
  `U2U8_ASSERT(a_no_underflow, pop_i |-> valid_o, "job popped from empty queue")

endmodule

FILE: sv/u2u8_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8_back
// serializes queued jobs into one utf-8 byte per beat through an output register
// ---------------------------------------------------------------------------
`include "utf16_to_utf8_encoder_core_assert.svh"

module u2u8_back
  import u2u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_data_i,
  output logic        pop_o,
  u2u8_byte_if.source out_o
);

  job_t              cur_q, cur_d;
  logic              cur_v_q, cur_v_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              ov_q, ov_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              rl_q, rl_d, se_q, se_d;
  logic              load, emit, is_last;

  assign load    = !ov_q || out_o.ready;
  assign emit    = load && cur_v_q;
  assign is_last = (idx_q + 1'b1) == cur_q.cnt;
  assign pop_o   = q_valid_i && (!cur_v_q || (emit && is_last));

  always_comb begin
    cur_d   = cur_q;
    cur_v_d = cur_v_q;
    idx_d   = idx_q;
    if (pop_o) begin
      cur_d   = q_data_i;
      cur_v_d = 1'b1;
      idx_d   = '0;
    end else if (emit) begin
      if (is_last) begin
        cur_v_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    ov_d   = ov_q;
    byte_d = byte_q;
    rl_d   = rl_q;
    se_d   = se_q;
    if (load) begin
      ov_d   = emit;
      byte_d = cur_q.b[idx_q];
      rl_d   = is_last;
      se_d   = is_last && cur_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    rl_q   <= rl_d;
    se_q   <= se_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.run_last   = rl_q;
  assign out_o.string_end = se_q;

  `U2U8_ASSERT(a_end_closes_run, ov_q && se_q |-> rl_q, "string end without run end")
  `U2U8_ASSERT(a_idx_in_job, cur_v_q |-> idx_q < cur_q.cnt, "byte index past job length")

endmodule

FILE: sv/utf16_to_utf8_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// utf-16 code unit stream to utf-8 byte stream encoder
// ---------------------------------------------------------------------------
// The block takes one utf-16 code unit per beat on in_i and sends utf-8 bytes,
// one per beat, on out_o. A unit can be taken every cycle while the job queue
// has room; the output side moves one byte per cycle while out_o is ready, and
// an item yields as many bytes as its job holds: 1 to 3 for a basic plane unit,
// 4 for a surrogate pair (all on its low half, none on the high half), and up to
// 6 when a dangling high surrogate is flushed ahead of the next unit. The first
// byte of a unit passes through the job queue, the back half's job register and
// the output register. run_last marks the last byte of each unit's run and
// string_end the last byte of a unit flagged last_unit; a high surrogate never
// stays held past the end of a string.
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder_core
  import u2u8_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u2u8_unit_if.sink   in_i,
  u2u8_byte_if.source out_o
);

  // job handoff between front and back halves
  logic push, full, pop, q_valid;
  job_t push_job, pop_job;

  // front: surrogate pairing and per-unit byte job build
  u2u8_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // queue lets a long job drain while new units keep arriving
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  // back: one byte per beat through the output register
  u2u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (pop_job),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

FILE: bench/u2u8_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2u8_stream_checker
// watches both channels of the encoder, predicts the utf-8 beats of every
// accepted code unit and scores each output beat against the oldest one
// ---------------------------------------------------------------------------
module u2u8_stream_checker
  import u2u8_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              unit_valid_i,
  input  logic              unit_ready_i,
  input  logic [UNIT_W-1:0] code_unit_i,
  input  logic              last_unit_i,
  input  logic              byte_valid_i,
  input  logic              byte_ready_i,
  input  logic [BYTE_W-1:0] out_byte_i,
  input  logic              run_last_i,
  input  logic              string_end_i,
  output int                errors_o,
  output int                pending_o,
  output int                beats_seen_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              str_end;
  } utf8_beat_t;

  utf8_beat_t        utf8_expect_q[$];
  logic [HELD_W-1:0] held_bits = '0;
  logic              high_held = 1'b0;
  int                errors = 0;
  int                beats_seen = 0;

  function automatic void push_utf8(input logic [BYTE_W-1:0] data);
    utf8_beat_t beat;
    beat = '{data, 1'b0, 1'b0};
    utf8_expect_q.insert(utf8_expect_q.size(), beat);
  endfunction

  function automatic void encode_code_point(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      push_utf8({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      push_utf8({3'b110, cp[10:6]});
      push_utf8({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_utf8({4'b1110, cp[15:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end else begin
      push_utf8({5'b11110, cp[20:18]});
      push_utf8({2'b10, cp[17:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end
  endfunction

  // bytes caused by one unit, with the held high surrogate resolved first
  function automatic void predict_utf8(input logic [UNIT_W-1:0] cu, input logic lst);
    int   first;
    logic is_high;
    logic is_low;
    first   = utf8_expect_q.size();
    is_high = cu[15:10] == HIGH_SURR_TAG;
    is_low  = cu[15:10] == LOW_SURR_TAG;
    if (high_held && is_low) begin
      encode_code_point(21'h10000 + {1'b0, held_bits, cu[9:0]});
      high_held = 1'b0;
      held_bits = '0;
    end else begin
      if (high_held) begin
        encode_code_point({5'b0, HIGH_SURR_TAG, held_bits});
        high_held = 1'b0;
        held_bits = '0;
      end
      if (is_high && !lst) begin
        held_bits = cu[9:0];
        high_held = 1'b1;
      end else begin
        encode_code_point({5'b0, cu});
      end
    end
    if (utf8_expect_q.size() > first) begin
      utf8_expect_q[utf8_expect_q.size()-1].run_end = 1'b1;
      utf8_expect_q[utf8_expect_q.size()-1].str_end = lst;
    end
  endfunction

  always @(posedge clk_i) begin
    utf8_beat_t want;
    if (!rst_ni) begin
      held_bits = '0;
      high_held = 1'b0;
      utf8_expect_q.delete();
    end else begin
      // a beat leaving now always belongs to an earlier unit
      if (byte_valid_i && byte_ready_i) begin
        beats_seen++;
        if (utf8_expect_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected beat byte=%02h run_last=%b string_end=%b",
                     $realtime, out_byte_i, run_last_i, string_end_i);
          errors++;
        end else begin
          want = utf8_expect_q.pop_front();
          if (out_byte_i !== want.data || run_last_i !== want.run_end ||
              string_end_i !== want.str_end) begin
            if (errors < 10)
              $display("%0t: beat mismatch exp byte=%02h run_last=%b string_end=%b, got %02h %b %b",
                       $realtime, want.data, want.run_end, want.str_end,
                       out_byte_i, run_last_i, string_end_i);
            errors++;
          end
        end
      end
      if (unit_valid_i && unit_ready_i) predict_utf8(code_unit_i, last_unit_i);
    end
    errors_o     <= errors;
    pending_o    <= utf8_expect_q.size();
    beats_seen_o <= beats_seen;
  end

endmodule

FILE: bench/utf16_to_utf8_encoder_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf16_to_utf8_encoder_core_test
// feeds strings of utf-16 units into the encoder, directed corner cases first,
// then random strings rich in surrogate pairs, with random stalls on both
// channels; u2u8_stream_checker predicts and scores every utf-8 beat
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder_core_test;
  import u2u8_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomUnits = 260;
  localparam int unsigned DrainCycles = 20;

  logic        clk;
  logic        rst_n;
  bit          steady = 1'b0;   // both sides run without idling while set
  int unsigned cycles;
  int unsigned ready_hold = 0;
  int unsigned units_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned pairs_sent = 0;
  int          errors;
  int          pending;
  int          beats_seen;

  u2u8_unit_if unit_ch ();
  u2u8_byte_if byte_ch ();

  utf16_to_utf8_encoder_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (unit_ch),
    .out_o  (byte_ch)
  );

  u2u8_stream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .unit_valid_i (unit_ch.valid),
    .unit_ready_i (unit_ch.ready),
    .code_unit_i  (unit_ch.code_unit),
    .last_unit_i  (unit_ch.last_unit),
    .byte_valid_i (byte_ch.valid),
    .byte_ready_i (byte_ch.ready),
    .out_byte_i   (byte_ch.out_byte),
    .run_last_i   (byte_ch.run_last),
    .string_end_i (byte_ch.string_end),
    .errors_o     (errors),
    .pending_o    (pending),
    .beats_seen_o (beats_seen)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: ready drops for random stretches unless the steady window is on
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) ready_hold <= idle_len();
    end
  end

  // one beat on the unit channel; valid stays up across back-to-back beats
  task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic lst);
    int unsigned gap;
    unit_ch.valid     <= 1'b1;
    unit_ch.code_unit <= cu;
    unit_ch.last_unit <= lst;
    @(posedge clk);
    while (!unit_ch.ready) @(posedge clk);
    units_sent++;
    if (lst) strings_sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      unit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // timeout watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [UNIT_W-1:0] text[$];
    int unsigned       len;
    int unsigned       kind;
    int unsigned       str_idx;
    int unsigned       random_units;

    unit_ch.valid     = 1'b0;
    unit_ch.code_unit = '0;
    unit_ch.last_unit = 1'b0;
    byte_ch.ready     = 1'b0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range edges of each encoding length
    send_unit(16'h0000, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b1);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest surrogate pairs, the second pair mid-string
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b1);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'h0041, 1'b1);
    // lone low surrogate as the whole string
    send_unit(16'hDC00, 1'b1);
    // held high followed by a plain unit flushes it as three bytes
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0041, 1'b1);
    // high, high, low: first high flushed, second one pairs
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hDB00, 1'b0);
    send_unit(16'hDC05, 1'b1);
    // high surrogate as the last unit goes out at once
    send_unit(16'hDB12, 1'b1);
    // flush plus a three-byte unit: six beats from one unit
    send_unit(16'hD955, 1'b0);
    send_unit(16'h20AC, 1'b1);
    // held high then a high that closes the string: six beats as well
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    // no pairing across a string boundary
    send_unit(16'hD888, 1'b1);
    send_unit(16'hDC00, 1'b1);

    // random strings, mostly well-formed text with some broken surrogates
    random_units = 0;
    str_idx      = 0;
    while (random_units < RandomUnits) begin
      len = $urandom_range(1, 8);
      text.delete();
      while (text.size() < len) begin
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          text.insert(text.size(), UNIT_W'($urandom_range(0, 16'h007F)));
        end else if (kind < 40) begin
          text.insert(text.size(), UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
        end else if (kind < 60) begin
          text.insert(text.size(), UNIT_W'($urandom_range(0, 16'hFFFF)));
        end else if (kind < 88) begin
          text.insert(text.size(), {HIGH_SURR_TAG, 10'($urandom_range(0, 1023))});
          text.insert(text.size(), {LOW_SURR_TAG, 10'($urandom_range(0, 1023))});
          pairs_sent++;
        end else if (kind < 94) begin
          text.insert(text.size(), {HIGH_SURR_TAG, 10'($urandom_range(0, 1023))});
        end else begin
          text.insert(text.size(), {LOW_SURR_TAG, 10'($urandom_range(0, 1023))});
        end
      end

      // a stretch with no idling on either side
      steady = str_idx >= 20 && str_idx < 30;

      // once, hold the sender back until every pending beat has drained
      if (str_idx == 12) begin
        unit_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end

      foreach (text[i]) send_unit(text[i], i == text.size() - 1);
      random_units += text.size();
      str_idx++;
    end
    unit_ch.valid <= 1'b0;
    steady = 1'b0;

    // drain the output side, then allow for the pipeline latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d code units in %0d strings, %0d random surrogate pairs among them",
             units_sent, strings_sent, pairs_sent);
    $display("%0d utf-8 beats scored, %0d of them wrong or unexpected", beats_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/u2u8_pkg.sv
sv/u2u8_if.sv
sv/u2u8_front.sv
sv/u2u8_queue.sv
sv/u2u8_back.sv
sv/utf16_to_utf8_encoder_core.sv
bench/u2u8_stream_checker.sv
bench/utf16_to_utf8_encoder_core_test.sv
